// ===== src/wrr_pkg.sv =====
// Shared constants, command codes and controller/datapath interface types
// for the weighted random replacement block. No dependencies.
package wrr_pkg;

	localparam int NUM_SETS    = 64;
	localparam int NUM_WAYS    = 8;
	localparam int WEIGHT_BITS = 8;
	localparam int RAND_BITS   = 16;

	// fixed field widths of the item ports
	localparam int CMD_W  = 2;
	localparam int SET_W  = 6;
	localparam int WAY_W  = 3;
	localparam int RAND_W = 16;

	localparam int ROW_ADDR_W = $clog2(NUM_SETS);
	localparam int WGT_FIELD  = NUM_WAYS * WEIGHT_BITS;
	localparam int ROW_W      = WGT_FIELD + NUM_WAYS;
	localparam int SUM_W      = WEIGHT_BITS + $clog2(NUM_WAYS) + 1;
	localparam int PROD_W     = RAND_BITS + SUM_W;

	typedef enum logic [CMD_W-1:0] {
		CMD_TOUCH  = 2'd0,
		CMD_FILL   = 2'd1,
		CMD_INVAL  = 2'd2,
		CMD_VICTIM = 2'd3
	} cmd_t;

	typedef struct packed {
		logic accept;     // capture item, start row read
		logic write_row;  // write back updated row
		logic load_sum;   // register prefix sums
		logic load_draw;  // register scaled draw
		logic sel_scan;   // result comes from weighted scan
		logic res_load;   // park result while output is busy
		logic out_load;   // load output register
		logic out_hold;   // output loads from parked result
	} ctrl_cmd_t;

	typedef struct packed {
		logic is_update;
		logic has_invalid;
	} dp_stat_t;

endpackage

// ===== src/wrr_ctrl.sv =====
// Sequencing state machine for the replacement block.
// Depends on wrr_pkg for the command and status types.
module wrr_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic                 out_ready,
	output logic                 out_valid,
	input  wrr_pkg::dp_stat_t    stat,
	output wrr_pkg::ctrl_cmd_t   cmd
);

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_EVAL = 5'b00010,
		ST_MUL  = 5'b00100,
		ST_SCAN = 5'b01000,
		ST_HOLD = 5'b10000
	} state_t;

	state_t state_q, state_d;
	logic   out_valid_q;
	logic   out_free;

	assign out_free  = !out_valid_q || out_ready;
	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.accept = 1'b1;
					state_d    = ST_EVAL;
				end
			end
			ST_EVAL: begin
				cmd.write_row = stat.is_update;
				if (stat.is_update || stat.has_invalid) begin
					if (out_free) begin
						cmd.out_load = 1'b1;
						state_d      = ST_IDLE;
					end else begin
						cmd.res_load = 1'b1;
						state_d      = ST_HOLD;
					end
				end else begin
					cmd.load_sum = 1'b1;
					state_d      = ST_MUL;
				end
			end
			ST_MUL: begin
				cmd.load_draw = 1'b1;
				state_d       = ST_SCAN;
			end
			ST_SCAN: begin
				cmd.sel_scan = 1'b1;
				if (out_free) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end else begin
					cmd.res_load = 1'b1;
					state_d      = ST_HOLD;
				end
			end
			ST_HOLD: begin
				cmd.out_hold = 1'b1;
				if (out_free) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// ===== src/wrr_dp.sv =====
// Datapath: per-set row memory of weights and valid bits, row update,
// invalid-way search, weight sums, scaled draw and weighted scan.
// Depends on wrr_pkg.
module wrr_dp (
	input  logic                                clk,
	input  logic                                arst_n,
	input  wrr_pkg::ctrl_cmd_t                  cmd,
	output wrr_pkg::dp_stat_t                   stat,
	input  logic [wrr_pkg::CMD_W-1:0]           command,
	input  logic [wrr_pkg::SET_W-1:0]           set_index,
	input  logic [wrr_pkg::WAY_W-1:0]           way,
	input  logic [wrr_pkg::RAND_W-1:0]          random_bits,
	output logic [wrr_pkg::WAY_W-1:0]           victim_way,
	output logic                                chose_invalid
);

	// row memory; a row never written reads as the reset value
	logic [wrr_pkg::ROW_W-1:0]      mem [wrr_pkg::NUM_SETS];
	logic [wrr_pkg::NUM_SETS-1:0]   row_vld_q;

	wrr_pkg::cmd_t                  cmd_q;
	logic [wrr_pkg::ROW_ADDR_W-1:0] set_q;
	logic [wrr_pkg::WAY_W-1:0]      way_q;
	logic [wrr_pkg::RAND_BITS-1:0]  rand_q;
	logic [wrr_pkg::ROW_W-1:0]      rd_s1;
	logic                           rv_s1;

	logic [wrr_pkg::WEIGHT_BITS-1:0] wgt  [wrr_pkg::NUM_WAYS];
	logic [wrr_pkg::NUM_WAYS-1:0]    vld;
	logic [wrr_pkg::ROW_W-1:0]       new_row;
	logic [wrr_pkg::SUM_W-1:0]       pre  [wrr_pkg::NUM_WAYS];
	logic [wrr_pkg::SUM_W-1:0]       pre_q [wrr_pkg::NUM_WAYS];
	logic [wrr_pkg::SUM_W-1:0]       draw_q;
	logic [wrr_pkg::PROD_W-1:0]      prod;

	logic [wrr_pkg::WAY_W-1:0] inv_way;
	logic [wrr_pkg::WAY_W-1:0] scan_way;
	logic [wrr_pkg::WAY_W-1:0] res_way;
	logic                      res_inv;
	logic [wrr_pkg::WAY_W-1:0] res_way_q;
	logic                      res_inv_q;
	logic [wrr_pkg::WAY_W-1:0] out_way_q;
	logic                      out_inv_q;

	// item capture and registered row read
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			cmd_q  <= wrr_pkg::cmd_t'(command);
			set_q  <= set_index[wrr_pkg::ROW_ADDR_W-1:0];
			way_q  <= way;
			rand_q <= random_bits[wrr_pkg::RAND_BITS-1:0];
			rd_s1  <= mem[set_index[wrr_pkg::ROW_ADDR_W-1:0]];
			rv_s1  <= row_vld_q[set_index[wrr_pkg::ROW_ADDR_W-1:0]];
		end
		if (cmd.write_row) begin
			mem[set_q] <= new_row;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_vld_q <= '0;
		end else if (cmd.write_row) begin
			row_vld_q[set_q] <= 1'b1;
		end
	end

	// unpack row, masked to zero while the row is still at reset
	always_comb begin
		for (int i = 0; i < wrr_pkg::NUM_WAYS; i++) begin
			wgt[i] = rv_s1 ? rd_s1[i*wrr_pkg::WEIGHT_BITS +: wrr_pkg::WEIGHT_BITS] : '0;
			vld[i] = rv_s1 ? rd_s1[wrr_pkg::WGT_FIELD + i] : 1'b0;
		end
	end

	// touch / fill / invalidate of the addressed way
	always_comb begin
		new_row = '0;
		for (int i = 0; i < wrr_pkg::NUM_WAYS; i++) begin
			logic [wrr_pkg::WEIGHT_BITS-1:0] w;
			logic                            v;
			w = wgt[i];
			v = vld[i];
			if (way_q == wrr_pkg::WAY_W'(i)) begin
				unique case (cmd_q)
					wrr_pkg::CMD_TOUCH: begin
						// hold at the top of the weight range
						if (w != '1) w = w + 1'b1;
					end
					wrr_pkg::CMD_FILL: begin
						w = wrr_pkg::WEIGHT_BITS'(1);
						v = 1'b1;
					end
					wrr_pkg::CMD_INVAL: begin
						w = '0;
						v = 1'b0;
					end
					wrr_pkg::CMD_VICTIM: begin
					end
				endcase
			end
			new_row[i*wrr_pkg::WEIGHT_BITS +: wrr_pkg::WEIGHT_BITS] = w;
			new_row[wrr_pkg::WGT_FIELD + i]                         = v;
		end
	end

	// lowest invalid way and running weight totals
	always_comb begin
		inv_way = '0;
		for (int i = wrr_pkg::NUM_WAYS - 1; i >= 0; i--) begin
			if (!vld[i]) inv_way = wrr_pkg::WAY_W'(i);
		end
		pre[0] = wrr_pkg::SUM_W'(wgt[0]);
		for (int i = 1; i < wrr_pkg::NUM_WAYS; i++) begin
			pre[i] = pre[i-1] + wrr_pkg::SUM_W'(wgt[i]);
		end
	end

	assign stat.is_update   = (cmd_q != wrr_pkg::CMD_VICTIM);
	assign stat.has_invalid = !(&vld);

	assign prod = wrr_pkg::PROD_W'(rand_q)
		* wrr_pkg::PROD_W'(pre_q[wrr_pkg::NUM_WAYS-1] + wrr_pkg::SUM_W'(1));

	always_ff @(posedge clk) begin
		if (cmd.load_sum) begin
			for (int i = 0; i < wrr_pkg::NUM_WAYS; i++) begin
				pre_q[i] <= pre[i];
			end
		end
		if (cmd.load_draw) begin
			draw_q <= prod[wrr_pkg::PROD_W-1:wrr_pkg::RAND_BITS];
		end
	end

	// first way whose running total reaches the draw
	always_comb begin
		scan_way = '0;
		for (int i = wrr_pkg::NUM_WAYS - 1; i >= 0; i--) begin
			if (pre_q[i] >= draw_q) scan_way = wrr_pkg::WAY_W'(i);
		end
	end

	always_comb begin
		priority if (cmd.sel_scan) begin
			res_way = scan_way;
			res_inv = 1'b0;
		end else if (stat.is_update) begin
			res_way = '0;
			res_inv = 1'b0;
		end else begin
			res_way = inv_way;
			res_inv = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.res_load) begin
			res_way_q <= res_way;
			res_inv_q <= res_inv;
		end
		if (cmd.out_load) begin
			out_way_q <= cmd.out_hold ? res_way_q : res_way;
			out_inv_q <= cmd.out_hold ? res_inv_q : res_inv;
		end
	end

	assign victim_way    = out_way_q;
	assign chose_invalid = out_inv_q;

endmodule

// ===== src/weighted_random_replacement_top.sv =====
// Weighted random replacement state for a 64-set, 8-way cache. A touch, fill or
// invalidate item has its row read at the accepting edge; in the EVAL state the row
// is written back and the result loads into the output register. A victim request
// that finds an invalid way also loads its result from EVAL. A weighted draw steps
// through EVAL, MUL and SCAN (sum, 16x12 multiply, scan) before its result loads.
// Only one item is in flight at a time: the block takes no new item until the
// result of the last one loads. The next item is accepted in the cycle after the
// result loads, even if that result is still waiting. If the output register is
// still full when a result is ready, the result is parked and the input stalls
// until the output is taken. There is no clearing pass after reset: per-set valid
// flops mark rows not yet written, which read as zero weights and invalid ways.
// Depends on wrr_pkg, wrr_ctrl and wrr_dp.
module weighted_random_replacement_top (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [wrr_pkg::CMD_W-1:0]  command,
	input  logic [wrr_pkg::SET_W-1:0]  set_index,
	input  logic [wrr_pkg::WAY_W-1:0]  way,
	input  logic [wrr_pkg::RAND_W-1:0] random_bits,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [wrr_pkg::WAY_W-1:0]  victim_way,
	output logic                       chose_invalid
);

	wrr_pkg::ctrl_cmd_t cmd;
	wrr_pkg::dp_stat_t  stat;

	wrr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_ready (out_ready),
		.out_valid (out_valid),
		.stat      (stat),
		.cmd       (cmd)
	);

	wrr_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.stat          (stat),
		.command       (command),
		.set_index     (set_index),
		.way           (way),
		.random_bits   (random_bits),
		.victim_way    (victim_way),
		.chose_invalid (chose_invalid)
	);

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("item accepted while previous item in flight");

	a_out_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!out_valid || out_ready))
		else $error("output overwritten before taken");

	a_write_not_draw: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.write_row |-> !cmd.load_sum && !cmd.load_draw)
		else $error("row write-back during victim draw");

	a_load_once: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |=> !cmd.out_load)
		else $error("two results loaded for one item");

endmodule
